// ===== hdl/imu_ws_pkg.sv =====
// imu_ws_pkg: shared types and constants of the imu window slicer
// holds the beat structs, the queued command struct and the register indexes
// no dependencies
`default_nettype none

package imu_ws_pkg;

    // widths fixed by the field list
    localparam int STAMP_W   = 63;
    localparam int PAYLOAD_W = 64;
    localparam int WIDE_W    = 64;
    localparam int INDEX_W   = 5;
    localparam int DROP_W    = 32;
    localparam int MARGIN_W  = 32;
    localparam int MAXPF_W   = 6;

    // defaults for the top level parameters
    localparam int RING_DEPTH_DEF = 64;
    localparam int MAX_KEPT_DEF   = 32;

    // hard cap on results for one window request
    localparam int RESULT_CAP = 32;

    // command queue between front and back (power of two depth)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // input command codes
    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_WINDOW = 1'b1;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_MARGIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_FRAME = 1'd1;

    localparam logic [MAXPF_W-1:0] MAX_PER_FRAME_RST = 6'd32;

    // input beat
    typedef struct packed {
        logic                 command;
        logic [STAMP_W-1:0]   imu_stamp;
        logic [PAYLOAD_W-1:0] imu_payload;
        logic [STAMP_W-1:0]   scan_begin;
        logic [STAMP_W-1:0]   scan_end;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic                 sample_valid;
        logic [STAMP_W-1:0]   sample_stamp;
        logic [PAYLOAD_W-1:0] sample_payload;
        logic [INDEX_W-1:0]   sample_index;
        logic                 last;
        logic [DROP_W-1:0]    dropped_total;
    } t_out_item;

    // classified command: push carries {0,stamp} / payload,
    // window request carries signed widened begin / unsigned widened end
    typedef struct packed {
        logic              is_req;
        logic [WIDE_W-1:0] a;
        logic [WIDE_W-1:0] b;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hdl/imu_window_slicer.sv =====
// imu_window_slicer: top level, configuration registers and the two halves
// input beats carry imu pushes or lidar window requests; output beats
// carry the selected samples. depends on imu_ws_pkg, imu_ws_front, imu_ws_back
//
// channels: input beat on i_in_valid / o_in_stall, output beat on
// o_out_valid / i_out_stall, register writes on i_cfg_valid / o_cfg_ready
// (always ready). registers: slice margin and max samples per frame.
// a four-entry command queue sits between the front and the ring walker.
// the walker executes a push as it pops it, so pushes flow at one per cycle
// while no window request is in progress. a window request leaves the queue,
// then each ring entry it reads is read into a register and then compared, in
// the discard before, the walk and the discard after; a phase may end without
// a read, and the final beat follows.
// on an empty ring the only output beat is the empty marker; otherwise each
// sample waits until the next one is checked.
// reset empties the ring, clears the drop counter and sets the registers
// to margin 0 and 32 samples per frame; ring contents are not cleared.
// while the receiver stalls, the output register holds its beat and the
// walker waits when it has a beat to emit; the queue keeps taking beats until it is full.
`default_nettype none

module imu_window_slicer #(
    parameter int RING_DEPTH = imu_ws_pkg::RING_DEPTH_DEF,
    parameter int MAX_KEPT   = imu_ws_pkg::MAX_KEPT_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire imu_ws_pkg::t_in_item                  i_in_item,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output imu_ws_pkg::t_out_item                      o_out_item,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [imu_ws_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [imu_ws_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [imu_ws_pkg::MARGIN_W-1:0] r_margin;
    logic [imu_ws_pkg::MAXPF_W-1:0]  r_max_pf;
    logic                            w_cmd_valid;
    imu_ws_pkg::t_cmd                w_cmd;
    logic                            w_cmd_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
            r_max_pf <= imu_ws_pkg::MAX_PER_FRAME_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                imu_ws_pkg::CFG_SLICE_MARGIN: begin
                    r_margin <= i_cfg_data[imu_ws_pkg::MARGIN_W-1:0];
                end
                imu_ws_pkg::CFG_MAX_PER_FRAME: begin
                    r_max_pf <= i_cfg_data[imu_ws_pkg::MAXPF_W-1:0];
                end
                default: begin
                    r_margin <= r_margin;
                end
            endcase
        end
    end

    // accept, classify and queue
    imu_ws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_margin    (r_margin),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // ring and window walker
    imu_ws_back #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_KEPT   (MAX_KEPT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_max_pf    (r_max_pf),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

// ===== hdl/imu_ws_front.sv =====
// imu_ws_front: accepts input beats, classifies them and queues commands
// widens the scan window by the margin before queuing
// depends on imu_ws_pkg
`default_nettype none

module imu_ws_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire imu_ws_pkg::t_in_item                 i_in_item,
    input  wire logic [imu_ws_pkg::MARGIN_W-1:0]      i_margin,
    output logic                                      o_cmd_valid,
    output imu_ws_pkg::t_cmd                          o_cmd,
    input  wire logic                                 i_cmd_pop
);

    imu_ws_pkg::t_cmd                       r_mem [imu_ws_pkg::QUEUE_DEPTH];
    logic [imu_ws_pkg::QUEUE_AW-1:0]        r_wr, n_wr;
    logic [imu_ws_pkg::QUEUE_AW-1:0]        r_rd, n_rd;
    logic [imu_ws_pkg::QUEUE_CW-1:0]        r_count, n_count;
    imu_ws_pkg::t_cmd                       w_cmd;
    logic                                   w_accept;
    logic                                   w_pop;

    // queue full holds the sender off
    assign o_in_stall  = (r_count == imu_ws_pkg::QUEUE_CW'(imu_ws_pkg::QUEUE_DEPTH));
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_mem[r_rd];

    // classify the beat and widen the window
    always_comb begin
        w_cmd.is_req = (i_in_item.command == imu_ws_pkg::CMD_WINDOW);
        if (w_cmd.is_req) begin
            w_cmd.a = $unsigned($signed({1'b0, i_in_item.scan_begin})
                    - $signed({{(imu_ws_pkg::WIDE_W - imu_ws_pkg::MARGIN_W){1'b0}}, i_margin}));
            w_cmd.b = {1'b0, i_in_item.scan_end}
                    + {{(imu_ws_pkg::WIDE_W - imu_ws_pkg::MARGIN_W){1'b0}}, i_margin};
        end else begin
            w_cmd.a = {1'b0, i_in_item.imu_stamp};
            w_cmd.b = i_in_item.imu_payload;
        end
    end

    // pointer and fill updates
    always_comb begin
        n_wr    = w_accept ? r_wr + 1'b1 : r_wr;
        n_rd    = w_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (w_accept && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_accept && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/imu_ws_back.sv =====
// imu_ws_back: ring buffer of imu samples and the window walker
// executes queued pushes and window requests, owns the output register
// depends on imu_ws_pkg
`default_nettype none

module imu_ws_back #(
    parameter int RING_DEPTH = imu_ws_pkg::RING_DEPTH_DEF,
    parameter int MAX_KEPT   = imu_ws_pkg::MAX_KEPT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cmd_valid,
    input  wire imu_ws_pkg::t_cmd                  i_cmd,
    output logic                                   o_cmd_pop,
    input  wire logic [imu_ws_pkg::MAXPF_W-1:0]    i_max_pf,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output imu_ws_pkg::t_out_item                  o_out_item
);

    localparam int IDXW     = $clog2(RING_DEPTH);
    localparam int CNTW     = $clog2(RING_DEPTH + 1);
    localparam int KEEP_CAP = (MAX_KEPT < imu_ws_pkg::RESULT_CAP) ? MAX_KEPT
                                                                  : imu_ws_pkg::RESULT_CAP;
    localparam int KW       = $clog2(KEEP_CAP + 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_D1_RD = 8'b0000_0010,
        ST_D1_CK = 8'b0000_0100,
        ST_EM_RD = 8'b0000_1000,
        ST_EM_CK = 8'b0001_0000,
        ST_D2_RD = 8'b0010_0000,
        ST_D2_CK = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } t_state;

    // ring storage
    logic [imu_ws_pkg::STAMP_W-1:0]   r_ring_stamp   [RING_DEPTH];
    logic [imu_ws_pkg::PAYLOAD_W-1:0] r_ring_payload [RING_DEPTH];
    logic [imu_ws_pkg::STAMP_W-1:0]   r_rd_stamp;
    logic [imu_ws_pkg::PAYLOAD_W-1:0] r_rd_payload;

    // control state
    t_state                           r_state, n_state;
    logic [IDXW-1:0]                  r_head, n_head;
    logic [IDXW-1:0]                  r_tail, n_tail;
    logic [CNTW-1:0]                  r_count, n_count;
    logic [imu_ws_pkg::DROP_W-1:0]    r_drop, n_drop;
    logic [IDXW-1:0]                  r_ptr, n_ptr;
    logic [CNTW-1:0]                  r_walk, n_walk;
    logic [KW-1:0]                    r_kept, n_kept;
    logic [KW-1:0]                    r_limit, n_limit;
    logic                             r_pend_valid, n_pend_valid;
    logic                             r_out_valid;

    // request and pending payload
    logic [imu_ws_pkg::WIDE_W-1:0]    r_begin, n_begin;
    logic [imu_ws_pkg::WIDE_W-1:0]    r_end, n_end;
    logic [imu_ws_pkg::STAMP_W-1:0]   r_pend_stamp, n_pend_stamp;
    logic [imu_ws_pkg::PAYLOAD_W-1:0] r_pend_payload, n_pend_payload;
    logic [imu_ws_pkg::INDEX_W-1:0]   r_pend_index, n_pend_index;
    imu_ws_pkg::t_out_item            r_out_item;

    logic                             w_wr_en;
    logic                             w_rd_en;
    logic [IDXW-1:0]                  w_rd_addr;
    logic                             w_emit;
    imu_ws_pkg::t_out_item            w_emit_item;
    logic                             w_out_free;
    logic                             w_lt_begin;
    logic                             w_le_begin;
    logic                             w_gt_end;
    logic [KW-1:0]                    w_limit;

    function automatic logic [IDXW-1:0] f_inc(input logic [IDXW-1:0] p);
        logic [IDXW-1:0] q;
        if (p == IDXW'(RING_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // stamp compares against the widened window
    assign w_lt_begin = $signed({1'b0, r_rd_stamp}) <  $signed(r_begin);
    assign w_le_begin = $signed({1'b0, r_rd_stamp}) <= $signed(r_begin);
    assign w_gt_end   = {1'b0, r_rd_stamp} > r_end;

    // clamp of the per-frame limit
    always_comb begin
        if (i_max_pf == '0) begin
            w_limit = KW'(1);
        end else if (i_max_pf > imu_ws_pkg::MAXPF_W'(KEEP_CAP)) begin
            w_limit = KW'(KEEP_CAP);
        end else begin
            w_limit = KW'(i_max_pf);
        end
    end

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_drop         = r_drop;
        n_ptr          = r_ptr;
        n_walk         = r_walk;
        n_kept         = r_kept;
        n_limit        = r_limit;
        n_pend_valid   = r_pend_valid;
        n_begin        = r_begin;
        n_end          = r_end;
        n_pend_stamp   = r_pend_stamp;
        n_pend_payload = r_pend_payload;
        n_pend_index   = r_pend_index;
        o_cmd_pop      = 1'b0;
        w_wr_en        = 1'b0;
        w_rd_en        = 1'b0;
        w_rd_addr      = r_head;
        w_emit         = 1'b0;
        w_emit_item    = '0;
        w_emit_item.dropped_total = r_drop;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (!i_cmd.is_req) begin
                        // push: tail equals head when the ring is full
                        w_wr_en = 1'b1;
                        n_tail  = f_inc(r_tail);
                        if (r_count == CNTW'(RING_DEPTH)) begin
                            n_head = f_inc(r_head);
                            if (r_drop != '1) begin
                                n_drop = r_drop + 1'b1;
                            end
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_begin      = i_cmd.a;
                        n_end        = i_cmd.b;
                        n_limit      = w_limit;
                        n_kept       = '0;
                        n_pend_valid = 1'b0;
                        n_state      = ST_D1_RD;
                    end
                end
            end
            // discard samples older than the begin
            ST_D1_RD: begin
                if (r_count == '0) begin
                    n_ptr   = r_head;
                    n_walk  = '0;
                    n_state = ST_EM_RD;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = ST_D1_CK;
                end
            end
            ST_D1_CK: begin
                if (w_lt_begin) begin
                    n_head  = f_inc(r_head);
                    n_count = r_count - 1'b1;
                    n_state = ST_D1_RD;
                end else begin
                    n_ptr   = r_head;
                    n_walk  = '0;
                    n_state = ST_EM_RD;
                end
            end
            // walk forward and emit up to the end or the per-frame limit
            ST_EM_RD: begin
                if (r_walk == r_count || r_kept == r_limit) begin
                    n_state = ST_D2_RD;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_ptr;
                    n_state   = ST_EM_CK;
                end
            end
            ST_EM_CK: begin
                if (w_gt_end) begin
                    n_state = ST_D2_RD;
                end else if (!r_pend_valid || w_out_free) begin
                    // the held sample is known not to be last
                    if (r_pend_valid) begin
                        w_emit                     = 1'b1;
                        w_emit_item.sample_valid   = 1'b1;
                        w_emit_item.sample_stamp   = r_pend_stamp;
                        w_emit_item.sample_payload = r_pend_payload;
                        w_emit_item.sample_index   = r_pend_index;
                    end
                    n_pend_valid   = 1'b1;
                    n_pend_stamp   = r_rd_stamp;
                    n_pend_payload = r_rd_payload;
                    n_pend_index   = imu_ws_pkg::INDEX_W'(r_kept);
                    n_kept         = r_kept + 1'b1;
                    n_ptr          = f_inc(r_ptr);
                    n_walk         = r_walk + 1'b1;
                    n_state        = ST_EM_RD;
                end
            end
            // discard samples at or before the begin
            ST_D2_RD: begin
                if (r_count == '0) begin
                    n_state = ST_FIN;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = ST_D2_CK;
                end
            end
            ST_D2_CK: begin
                if (w_le_begin) begin
                    n_head  = f_inc(r_head);
                    n_count = r_count - 1'b1;
                    n_state = ST_D2_RD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            // final beat: held sample marked last, or the empty marker
            ST_FIN: begin
                if (w_out_free) begin
                    w_emit           = 1'b1;
                    w_emit_item.last = 1'b1;
                    if (r_pend_valid) begin
                        w_emit_item.sample_valid   = 1'b1;
                        w_emit_item.sample_stamp   = r_pend_stamp;
                        w_emit_item.sample_payload = r_pend_payload;
                        w_emit_item.sample_index   = r_pend_index;
                    end
                    n_pend_valid = 1'b0;
                    if (r_count == '0) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_drop       <= '0;
            r_ptr        <= '0;
            r_walk       <= '0;
            r_kept       <= '0;
            r_limit      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_drop       <= n_drop;
            r_ptr        <= n_ptr;
            r_walk       <= n_walk;
            r_kept       <= n_kept;
            r_limit      <= n_limit;
            r_pend_valid <= n_pend_valid;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_begin        <= n_begin;
        r_end          <= n_end;
        r_pend_stamp   <= n_pend_stamp;
        r_pend_payload <= n_pend_payload;
        r_pend_index   <= n_pend_index;
        if (w_emit) begin
            r_out_item <= w_emit_item;
        end
    end

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_ring_stamp[r_tail]   <= i_cmd.a[imu_ws_pkg::STAMP_W-1:0];
            r_ring_payload[r_tail] <= i_cmd.b;
        end
        if (w_rd_en) begin
            r_rd_stamp   <= r_ring_stamp[w_rd_addr];
            r_rd_payload <= r_ring_payload[w_rd_addr];
        end
    end

endmodule

`default_nettype wire
